/* sv/bitfield_pixel_to_rgb888_macros.svh */
`ifndef BITFIELD_PIXEL_TO_RGB888_MACROS_SVH
`define BITFIELD_PIXEL_TO_RGB888_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BP2RGB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BP2RGB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bp2rgb_pkg.sv */
package bp2rgb_pkg;

    localparam int PIX_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int PIX_BYTES  = 4;
    localparam int CH_N       = 3;
    localparam int COMP_W     = 8;
    localparam int BPP_W      = 3;
    localparam int OFF_W      = 5;
    localparam int LEN_W      = 6;
    localparam int IDX_W      = 3;
    localparam int CFG_DATA_W = 6;
    localparam int DIV_W      = PIX_W + COMP_W;
    localparam int DIV_STAGES = COMP_W;
    localparam int PIPE_DEPTH = 2 + DIV_STAGES;

    localparam logic [IDX_W-1:0] REG_BPP       = 3'd0;
    localparam logic [IDX_W-1:0] REG_RED_OFF   = 3'd1;
    localparam logic [IDX_W-1:0] REG_RED_LEN   = 3'd2;
    localparam logic [IDX_W-1:0] REG_GREEN_OFF = 3'd3;
    localparam logic [IDX_W-1:0] REG_GREEN_LEN = 3'd4;
    localparam logic [IDX_W-1:0] REG_BLUE_OFF  = 3'd5;
    localparam logic [IDX_W-1:0] REG_BLUE_LEN  = 3'd6;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef struct packed {
        logic [BPP_W-1:0]            byte_count;
        logic [CH_N-1:0][OFF_W-1:0]  offset;
        logic [CH_N-1:0][LEN_W-1:0]  length;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        byte_count: 3'd4,
        offset:     {5'd0, 5'd8, 5'd16},
        length:     {6'd8, 6'd8, 6'd8}
    };

    typedef struct packed {
        logic             absent;
        logic [PIX_W-1:0] value;
        logic [PIX_W-1:0] mask;
    } field_t;

    typedef struct packed {
        logic              absent;
        logic [DIV_W-1:0]  rem;
        logic [DIV_W-1:0]  dvs;
        logic [COMP_W-1:0] quo;
    } div_t;

    typedef field_t [CH_N-1:0] field_vec_t;
    typedef div_t   [CH_N-1:0] div_vec_t;

endpackage

/* sv/bp2rgb_intf.sv */
interface bp2rgb_pix_if;
    import bp2rgb_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_bytes;

    modport source (output valid, output pixel_bytes, input ready);
    modport sink   (input valid, input pixel_bytes, output ready);
endinterface

interface bp2rgb_rgb_if;
    import bp2rgb_pkg::*;

    logic              valid;
    logic              ready;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface bp2rgb_cfg_if;
    import bp2rgb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [IDX_W-1:0]      index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/bitfield_pixel_to_rgb888.sv */
// Throughput: one pixel per cycle while rgb is not stalled; a field register and a dividend
// register gather the fields and form the dividend, then eight pipelined restoring steps
// form one quotient bit each.
// A stall on rgb holds every stage; pixel ready drops only while the last stage is stalled.
// Reset clears all stage valids and loads the default 8:8:8 layout, 4 bytes per pixel.
module bitfield_pixel_to_rgb888 (
    input  logic        clk,
    input  logic        rst_n,
    bp2rgb_pix_if.sink  pixel,
    bp2rgb_rgb_if.source rgb,
    bp2rgb_cfg_if.sink  cfg
);
    import bp2rgb_pkg::*;

    cfg_t                  regs;
    logic                  adv;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    div_vec_t              div_chain [DIV_STAGES+1];
    div_vec_t              last;

    bp2rgb_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    bp2rgb_front u_front (
        .clk         (clk),
        .adv         (adv),
        .regs        (regs),
        .pixel_bytes (pixel.pixel_bytes),
        .div_out     (div_chain[0])
    );

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        bp2rgb_div_stage u_div_stage (
            .clk     (clk),
            .adv     (adv),
            .div_in  (div_chain[s]),
            .div_out (div_chain[s+1])
        );
    end

    assign adv         = !valid_reg[PIPE_DEPTH-1] || rgb.ready;
    assign pixel.ready = adv;
    assign valid_next  = adv ? {valid_reg[PIPE_DEPTH-2:0], pixel.valid} : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign last      = div_chain[DIV_STAGES];
    assign rgb.valid = valid_reg[PIPE_DEPTH-1];
    assign rgb.red   = last[CH_RED].absent   ? '0 : last[CH_RED].quo;
    assign rgb.green = last[CH_GREEN].absent ? '0 : last[CH_GREEN].quo;
    assign rgb.blue  = last[CH_BLUE].absent  ? '0 : last[CH_BLUE].quo;

endmodule

/* sv/bp2rgb_cfg_regs.sv */
module bp2rgb_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    bp2rgb_cfg_if.sink        cfg,
    output bp2rgb_pkg::cfg_t  regs
);
    import bp2rgb_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_BPP:       regs_next.byte_count       = cfg.data[BPP_W-1:0];
                REG_RED_OFF:   regs_next.offset[CH_RED]   = cfg.data[OFF_W-1:0];
                REG_RED_LEN:   regs_next.length[CH_RED]   = cfg.data[LEN_W-1:0];
                REG_GREEN_OFF: regs_next.offset[CH_GREEN] = cfg.data[OFF_W-1:0];
                REG_GREEN_LEN: regs_next.length[CH_GREEN] = cfg.data[LEN_W-1:0];
                REG_BLUE_OFF:  regs_next.offset[CH_BLUE]  = cfg.data[OFF_W-1:0];
                REG_BLUE_LEN:  regs_next.length[CH_BLUE]  = cfg.data[LEN_W-1:0];
                default:       regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= CFG_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

/* sv/bp2rgb_front.sv */
module bp2rgb_front (
    input  logic                          clk,
    input  logic                          adv,
    input  bp2rgb_pkg::cfg_t              regs,
    input  logic [bp2rgb_pkg::PIX_W-1:0]  pixel_bytes,
    output bp2rgb_pkg::div_vec_t          div_out
);
    import bp2rgb_pkg::*;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PIX_W);

    logic [PIX_W-1:0] kept;
    logic [LEN_W-1:0] len_clamped [CH_N];
    field_vec_t       field_reg;
    field_vec_t       field_next;
    div_vec_t         div_reg;
    div_vec_t         div_next;

    // drop bytes beyond the byte count, then cut out each field
    always_comb
    begin
        for (int b = 0; b < PIX_BYTES; b++)
        begin
            kept[b*BYTE_W +: BYTE_W] = (BPP_W'(b) < regs.byte_count) ?
                                       pixel_bytes[b*BYTE_W +: BYTE_W] : '0;
        end
        for (int c = 0; c < CH_N; c++)
        begin
            len_clamped[c] = (regs.length[c] > LEN_MAX) ? LEN_MAX : regs.length[c];
            field_next[c].absent = (regs.length[c] == '0);
            field_next[c].mask   = (len_clamped[c] == LEN_MAX) ? '1 :
                                   ((PIX_W'(1) << len_clamped[c]) - PIX_W'(1));
            field_next[c].value  = (kept >> regs.offset[c]) & field_next[c].mask;
        end
    end

    // form value*255 + mask/2 and the divisor aligned to the top quotient bit
    always_comb
    begin
        for (int c = 0; c < CH_N; c++)
        begin
            div_next[c].absent = field_reg[c].absent;
            div_next[c].rem    = (DIV_W'(field_reg[c].value) << COMP_W)
                                 - DIV_W'(field_reg[c].value)
                                 + DIV_W'(field_reg[c].mask >> 1);
            div_next[c].dvs    = DIV_W'(field_reg[c].mask) << (COMP_W - 1);
            div_next[c].quo    = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            field_reg <= field_next;
            div_reg   <= div_next;
        end
    end

    assign div_out = div_reg;

endmodule

/* sv/bp2rgb_div_stage.sv */
module bp2rgb_div_stage (
    input  logic                  clk,
    input  logic                  adv,
    input  bp2rgb_pkg::div_vec_t  div_in,
    output bp2rgb_pkg::div_vec_t  div_out
);
    import bp2rgb_pkg::*;

    div_vec_t div_reg;
    div_vec_t div_next;

    // one restoring step: one quotient bit per channel
    always_comb
    begin
        for (int c = 0; c < CH_N; c++)
        begin
            div_next[c].absent = div_in[c].absent;
            div_next[c].dvs    = div_in[c].dvs >> 1;
            if (div_in[c].rem >= div_in[c].dvs)
            begin
                div_next[c].rem = div_in[c].rem - div_in[c].dvs;
                div_next[c].quo = {div_in[c].quo[COMP_W-2:0], 1'b1};
            end
            else
            begin
                div_next[c].rem = div_in[c].rem;
                div_next[c].quo = {div_in[c].quo[COMP_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_reg <= div_next;
        end
    end

    assign div_out = div_reg;

endmodule

/* sv/bp2rgb_checker.sv */
`include "bitfield_pixel_to_rgb888_macros.svh"

module bp2rgb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          pixel_valid,
    input logic                          pixel_ready,
    input logic                          rgb_valid,
    input logic                          rgb_ready,
    input logic [bp2rgb_pkg::COMP_W-1:0] red,
    input logic [bp2rgb_pkg::COMP_W-1:0] green,
    input logic [bp2rgb_pkg::COMP_W-1:0] blue
);
    import bp2rgb_pkg::*;

    logic [PIPE_DEPTH-1:0] acc_hist_reg;
    logic [PIPE_DEPTH-2:0] ready_hist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_hist_reg   <= '0;
            ready_hist_reg <= '0;
        end
        else
        begin
            acc_hist_reg   <= {acc_hist_reg[PIPE_DEPTH-2:0], pixel_valid && pixel_ready};
            ready_hist_reg <= {ready_hist_reg[PIPE_DEPTH-3:0], rgb_ready};
        end
    end

    `BP2RGB_ASSERT_NEXT(a_rgb_valid_hold, rgb_valid && !rgb_ready, rgb_valid,
        "rgb valid dropped while stalled")

    `BP2RGB_ASSERT_NEXT(a_rgb_data_hold, rgb_valid && !rgb_ready,
        $stable(red) && $stable(green) && $stable(blue), "rgb payload changed while stalled")

    `BP2RGB_ASSERT_IMPL(a_ready_when_empty, !rgb_valid, pixel_ready,
        "pixel not ready with empty output")

    `BP2RGB_ASSERT_IMPL(a_latency, acc_hist_reg[PIPE_DEPTH-1] && (&ready_hist_reg), rgb_valid,
        "no result after pipeline latency")

endmodule

bind bitfield_pixel_to_rgb888 bp2rgb_checker u_bp2rgb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel.valid),
    .pixel_ready (pixel.ready),
    .rgb_valid   (rgb.valid),
    .rgb_ready   (rgb.ready),
    .red         (rgb.red),
    .green       (rgb.green),
    .blue        (rgb.blue)
);
